// File: hw/rtl/spc_pkg.sv
// Types, constants and helpers shared by the signal phase controller.
`timescale 1ns / 1ps
package spc_pkg;

    localparam int HEADS  = 4;
    localparam int HEAD_W = $clog2(HEADS);
    localparam int AGE_W  = 16;
    localparam int CNT_W  = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    typedef enum logic [1:0] {
        ASPECT_STOP = 2'd0,
        ASPECT_WAIT = 2'd1,
        ASPECT_GO   = 2'd2
    } t_aspect;

    typedef enum logic [1:0] {
        PH_GREEN  = 2'd0,
        PH_YELLOW = 2'd1,
        PH_ALLRED = 2'd2
    } t_phase;

    localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE_ENABLE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_TICKS      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW_TICKS     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALL_RED_TICKS    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EVAL_INTERVAL    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GREEN_TICKS  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_QUEUE   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_GAP     = 4'd7;

    typedef struct packed {
        logic [CNT_W-1:0] waiting_0;
        logic [CNT_W-1:0] waiting_1;
        logic [CNT_W-1:0] waiting_2;
        logic [CNT_W-1:0] waiting_3;
    } t_tick;

    typedef struct packed {
        logic [1:0] light_0;
        logic [1:0] light_1;
        logic [1:0] light_2;
        logic [1:0] light_3;
        logic [1:0] timed_phase;
        logic       active_pair;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg;

    function automatic logic in_pair(input logic [HEAD_W-1:0] idx, input logic pair);
        return idx[0] != pair;
    endfunction

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] age);
        return (age == AGE_MAX) ? AGE_MAX : age + AGE_W'(1);
    endfunction

endpackage

// File: hw/rtl/spc_if.sv
// Valid/ready channel interfaces for tick, result and configuration beats.
`timescale 1ns / 1ps
interface spc_tick_if import spc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_tick data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spc_res_if import spc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spc_cfg_if import spc_pkg::*; ();
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/four_way_signal_phase_controller_unit.sv
// Four-way signal phase controller: timed and queue-driven adaptive modes.
// A result beat is valid in the cycle after its tick beat is taken.
// Throughput: one tick beat per cycle; the tick channel stalls only while
// the result register is full and the result sink holds ready low.
// Reset (synchronous, active low) loads the register defaults, heads 0 and 2
// go, heads 1 and 3 stop, green phase, zero ages and an empty result register.
`timescale 1ns / 1ps
module four_way_signal_phase_controller_unit
    import spc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    spc_tick_if.sink   i_tick,
    spc_res_if.source  o_res,
    spc_cfg_if.sink    i_cfg
);

    logic                  r_adaptive;
    logic [AGE_W-1:0]      r_green_ticks;
    logic [AGE_W-1:0]      r_yellow_ticks;
    logic [AGE_W-1:0]      r_all_red_ticks;
    logic [AGE_W-1:0]      r_eval_interval;
    logic [AGE_W-1:0]      r_min_green;
    logic [CNT_W-1:0]      r_prio_min;
    logic [AGE_W-1:0]      r_prio_gap;

    t_aspect               r_aspect    [HEADS];
    t_aspect               n_aspect    [HEADS];
    logic [AGE_W-1:0]      r_green_age [HEADS];
    logic [AGE_W-1:0]      n_green_age [HEADS];
    t_phase                r_phase;
    t_phase                n_phase;
    logic [AGE_W-1:0]      r_phase_age;
    logic [AGE_W-1:0]      n_phase_age;
    logic                  r_pair;
    logic                  n_pair;
    logic [AGE_W-1:0]      r_interval_age;
    logic [AGE_W-1:0]      n_interval_age;

    logic                  r_out_valid;
    t_result               r_out;
    t_result               n_out;

    logic [CNT_W-1:0]      w_wait [HEADS];
    logic                  w_acc;
    logic [AGE_W-1:0]      w_phase_len;
    logic                  w_advance;
    logic                  w_eval;
    logic [CNT_W-1:0]      w_max;
    logic [HEAD_W-1:0]     w_big;
    logic                  w_any_go;

    assign w_wait[0] = i_tick.data.waiting_0;
    assign w_wait[1] = i_tick.data.waiting_1;
    assign w_wait[2] = i_tick.data.waiting_2;
    assign w_wait[3] = i_tick.data.waiting_3;

    assign i_tick.ready = !r_out_valid || o_res.ready;
    assign w_acc        = i_tick.valid && i_tick.ready;
    assign i_cfg.ready  = 1'b1;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    always_comb begin
        unique case (r_phase)
            PH_GREEN:  w_phase_len = r_green_ticks;
            PH_YELLOW: w_phase_len = r_yellow_ticks;
            default:   w_phase_len = r_all_red_ticks;
        endcase
    end

    always_comb begin
        w_max = '0;
        w_big = '0;
        for (int i = 0; i < HEADS; i++) begin
            if (w_wait[i] > w_max) begin
                w_max = w_wait[i];
                w_big = HEAD_W'(i);
            end
        end
    end

    always_comb begin
        n_phase_age    = age_inc(r_phase_age);
        n_interval_age = age_inc(r_interval_age);
        n_phase        = r_phase;
        n_pair         = r_pair;
        for (int i = 0; i < HEADS; i++) begin
            n_green_age[i] = age_inc(r_green_age[i]);
            n_aspect[i]    = r_aspect[i];
        end
        w_advance = n_phase_age >= w_phase_len;
        w_eval    = n_interval_age >= r_eval_interval;
        w_any_go  = 1'b0;

        if (r_adaptive) begin
            if (w_eval) begin
                n_interval_age = '0;
                if (w_max != '0) begin
                    // release idle heads and heads past minimum green
                    for (int i = 0; i < HEADS; i++) begin
                        if (r_aspect[i] == ASPECT_GO &&
                            (w_wait[i] == '0 || n_green_age[i] >= r_min_green)) begin
                            n_aspect[i] = ASPECT_STOP;
                        end
                        if (n_aspect[i] == ASPECT_GO) begin
                            w_any_go = 1'b1;
                        end
                    end
                    if (!w_any_go) begin
                        if (w_max >= r_prio_min && n_green_age[w_big] >= r_prio_gap) begin
                            for (int i = 0; i < HEADS; i++) begin
                                n_aspect[i] = ASPECT_STOP;
                            end
                        end
                        n_aspect[w_big]    = ASPECT_GO;
                        n_green_age[w_big] = '0;
                    end
                end
            end
        end else if (w_advance) begin
            n_phase_age = '0;
            unique case (r_phase)
                PH_GREEN: begin
                    for (int i = 0; i < HEADS; i++) begin
                        n_aspect[i] = in_pair(HEAD_W'(i), r_pair) ? ASPECT_WAIT : ASPECT_STOP;
                    end
                    n_phase = PH_YELLOW;
                end
                PH_YELLOW: begin
                    for (int i = 0; i < HEADS; i++) begin
                        n_aspect[i] = ASPECT_STOP;
                    end
                    n_phase = PH_ALLRED;
                end
                default: begin
                    n_pair = ~r_pair;
                    for (int i = 0; i < HEADS; i++) begin
                        n_aspect[i] = in_pair(HEAD_W'(i), ~r_pair) ? ASPECT_GO : ASPECT_STOP;
                    end
                    n_phase = PH_GREEN;
                end
            endcase
        end

        n_out.light_0     = n_aspect[0];
        n_out.light_1     = n_aspect[1];
        n_out.light_2     = n_aspect[2];
        n_out.light_3     = n_aspect[3];
        n_out.timed_phase = n_phase;
        n_out.active_pair = n_pair;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adaptive      <= 1'b0;
            r_green_ticks   <= AGE_W'(100);
            r_yellow_ticks  <= AGE_W'(30);
            r_all_red_ticks <= AGE_W'(5);
            r_eval_interval <= AGE_W'(10);
            r_min_green     <= AGE_W'(50);
            r_prio_min      <= CNT_W'(3);
            r_prio_gap      <= AGE_W'(100);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                REG_ADAPTIVE_ENABLE: r_adaptive      <= i_cfg.data.value[0];
                REG_GREEN_TICKS:     r_green_ticks   <= i_cfg.data.value;
                REG_YELLOW_TICKS:    r_yellow_ticks  <= i_cfg.data.value;
                REG_ALL_RED_TICKS:   r_all_red_ticks <= i_cfg.data.value;
                REG_EVAL_INTERVAL:   r_eval_interval <= i_cfg.data.value;
                REG_MIN_GREEN_TICKS: r_min_green     <= i_cfg.data.value;
                REG_PRIORITY_QUEUE:  r_prio_min      <= i_cfg.data.value[CNT_W-1:0];
                REG_PRIORITY_GAP:    r_prio_gap      <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // controller state, advanced once per tick beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HEADS; i++) begin
                r_aspect[i]    <= in_pair(HEAD_W'(i), 1'b1) ? ASPECT_GO : ASPECT_STOP;
                r_green_age[i] <= '0;
            end
            r_phase        <= PH_GREEN;
            r_phase_age    <= '0;
            r_pair         <= 1'b1;
            r_interval_age <= '0;
        end else if (w_acc) begin
            for (int i = 0; i < HEADS; i++) begin
                r_aspect[i]    <= n_aspect[i];
                r_green_age[i] <= n_green_age[i];
            end
            r_phase        <= n_phase;
            r_phase_age    <= n_phase_age;
            r_pair         <= n_pair;
            r_interval_age <= n_interval_age;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_out_valid)
        else $error("result register not loaded after tick beat");

    a_eval_clears_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_adaptive && w_eval) |=> (r_interval_age == '0))
        else $error("interval age not cleared after evaluation");

    a_phase_age_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !r_adaptive && !w_advance) |=> (r_phase_age != '0))
        else $error("phase age cleared without phase advance");

    a_pair_toggles_at_allred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (r_adaptive || r_phase != PH_ALLRED)) |=> $stable(r_pair))
        else $error("pair changed outside all-red exit");

endmodule
